/* design/amcel_pkg.sv */
// Shared types and constants for the arm motor command envelope limiter.
`timescale 1ns / 1ps

package amcel_pkg;

  localparam int CmdW    = 16;
  localparam int CountW  = 16;
  localparam int ScaleW  = 24;
  localparam int GainW   = 16;
  localparam int EnvW    = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 32;
  localparam int ProdW   = ScaleW + CountW;
  localparam int AngleW  = 32;
  localparam int ErrW    = 24;
  localparam int CorrW   = GainW + 1 + ErrW;

  // angles in 1/64 degree
  localparam logic signed [AngleW-1:0] Angle90  = 32'sd5760;
  localparam logic signed [AngleW-1:0] Angle20  = 32'sd1280;
  localparam logic signed [AngleW-1:0] Angle160 = 32'sd10240;

  localparam logic signed [CountW-1:0] CenterCounts = 16'sd250;
  localparam logic signed [ProdW-1:0]  FwdLimitFine = 40'sd2949120;

  localparam logic signed [CmdW:0] LiftMinCmd = 17'sd11469;
  localparam logic signed [41:0]   CorrLimit  = 42'sd9830;

  // floor(2^32 / 875) for the turret minimum divide
  localparam logic [22:0] Recip875 = 23'd4908534;
  localparam logic [22:0] Div875   = 23'd875;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIFT_DPC    = 3'd0,
    CFG_TURRET_DPC  = 3'd1,
    CFG_TURRET_LOW  = 3'd2,
    CFG_TURRET_HIGH = 3'd3,
    CFG_LIFT_GAIN   = 3'd4,
    CFG_ENV_CENTER  = 3'd5,
    CFG_ENV_FORWARD = 3'd6,
    CFG_ENV_SIDE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic ang;
    logic prep;
    logic mul2;
    logic fin;
  } dp_cmd_t;

endpackage

/* design/amcel_ctrl.sv */
// Sequencing controller: walks one transaction through the datapath steps.
`timescale 1ns / 1ps

module amcel_ctrl import amcel_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANG,
    ST_PREP,
    ST_MUL2,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_go;

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ANG;
      ST_ANG:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load = in_ready && in_valid;
  assign cmd.ang  = (state_r == ST_ANG);
  assign cmd.prep = (state_r == ST_PREP);
  assign cmd.mul2 = (state_r == ST_MUL2);
  assign cmd.fin  = fin_go;

endmodule

/* design/amcel_dp.sv */
// Datapath: config registers, bypass toggle, angle, envelope and limit arithmetic.
`timescale 1ns / 1ps

module amcel_dp import amcel_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgW-1:0]          cfg_wdata,
  input  logic signed [CmdW-1:0]   in_lift_cmd,
  input  logic signed [CmdW-1:0]   in_turret_cmd,
  input  logic signed [CountW-1:0] in_lift_count,
  input  logic signed [CountW-1:0] in_turret_count,
  input  logic                     in_lift_is_pid,
  input  logic                     in_turret_is_pid,
  input  logic                     in_bypass_button,
  input  dp_cmd_t                  cmd,
  output logic signed [CmdW-1:0]   out_lift_out,
  output logic signed [CmdW-1:0]   out_turret_out,
  output logic                     out_bypass_active,
  output logic                     out_lift_corrected
);

  // configuration
  logic signed [ScaleW-1:0] lift_dpc_r, turret_dpc_r;
  logic signed [CountW-1:0] turret_low_r, turret_high_r;
  logic [GainW-1:0]         gain_r;
  logic [EnvW-1:0]          env_center_r, env_fwd_r, env_side_r;

  // bypass state
  logic bypass_on_r, prev_btn_r, bypass_nxt;

  // transaction registers
  logic signed [CmdW-1:0]   lcmd_r, tcmd_r;
  logic signed [CountW-1:0] tcnt_r;
  logic                     lpid_r, tpid_r, byp_r;
  logic signed [ProdW-1:0]  prod_l_r, prod_t_r;
  logic signed [AngleW-1:0] angle_r;
  logic                     tzero_r;
  logic signed [15:0]       emin_r, emax_r;
  logic                     corr_r;
  logic signed [ErrW-1:0]   err_r;
  logic [21:0]              x_r;
  logic signed [CorrW-1:0]  p_r;
  logic [12:0]              q0_r;

  logic signed [CmdW-1:0]   lift_out_r, turret_out_r;
  logic                     bypass_out_r, corrected_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_dpc_r    <= '0;
      turret_dpc_r  <= '0;
      turret_low_r  <= 16'sh8000;
      turret_high_r <= 16'sh7FFF;
      gain_r        <= '0;
      env_center_r  <= '0;
      env_fwd_r     <= '0;
      env_side_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIFT_DPC:    lift_dpc_r    <= cfg_wdata[ScaleW-1:0];
        CFG_TURRET_DPC:  turret_dpc_r  <= cfg_wdata[ScaleW-1:0];
        CFG_TURRET_LOW:  turret_low_r  <= cfg_wdata[CountW-1:0];
        CFG_TURRET_HIGH: turret_high_r <= cfg_wdata[CountW-1:0];
        CFG_LIFT_GAIN:   gain_r        <= cfg_wdata[GainW-1:0];
        CFG_ENV_CENTER:  env_center_r  <= cfg_wdata[EnvW-1:0];
        CFG_ENV_FORWARD: env_fwd_r     <= cfg_wdata[EnvW-1:0];
        CFG_ENV_SIDE:    env_side_r    <= cfg_wdata[EnvW-1:0];
      endcase
    end
  end

  assign bypass_nxt = bypass_on_r ^ (in_bypass_button && !prev_btn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_on_r <= 1'b0;
      prev_btn_r  <= 1'b0;
    end else if (cmd.load) begin
      bypass_on_r <= bypass_nxt;
      prev_btn_r  <= in_bypass_button;
    end
  end

  // load: capture fields and form both encoder products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lcmd_r   <= in_lift_cmd;
      tcmd_r   <= in_turret_cmd;
      tcnt_r   <= in_turret_count;
      lpid_r   <= in_lift_is_pid;
      tpid_r   <= in_turret_is_pid;
      byp_r    <= bypass_nxt;
      prod_l_r <= lift_dpc_r * in_lift_count;
      prod_t_r <= turret_dpc_r * in_turret_count;
    end
  end

  // angle, turret limit, envelope selection
  logic signed [AngleW-1:0] angle_c;
  logic [EnvW-1:0]          env_c;

  always_comb begin
    angle_c = AngleW'(prod_l_r >>> 10) + Angle90;
    if (tcnt_r <= CenterCounts && tcnt_r >= -CenterCounts) begin
      env_c = env_center_r;
    end else if (prod_t_r < FwdLimitFine && prod_t_r > -FwdLimitFine) begin
      env_c = env_fwd_r;
    end else begin
      env_c = env_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ang) begin
      angle_r <= angle_c;
      tzero_r <= (tcmd_r >= 0) ? (tcnt_r < turret_low_r) : (tcnt_r > turret_high_r);
      emin_r  <= env_c[15:0];
      emax_r  <= env_c[31:16];
    end
  end

  // envelope checks, error, turret minimum numerator
  logic                     below_c, above_c;
  logic signed [AngleW:0]   err_c;
  logic signed [ErrW-1:0]   err_sat_c;
  logic signed [AngleW-1:0] ac_c;
  logic [12:0]              d_c;
  logic [15:0]              span_c;
  logic [21:0]              x_c;

  always_comb begin
    below_c = (lcmd_r >= 0) && (angle_r < AngleW'(emin_r));
    above_c = (lcmd_r <= 0) && (angle_r > AngleW'(emax_r));
    if (below_c) err_c = (AngleW+1)'(emin_r) - (AngleW+1)'(angle_r);
    else         err_c = (AngleW+1)'(emax_r) - (AngleW+1)'(angle_r);
    // wide errors saturate; the clamp downstream hides the difference
    priority if (err_c > 33'sd8388607)       err_sat_c = 24'sh7FFFFF;
    else if (err_c < -33'sd8388608)           err_sat_c = 24'sh800000;
    else                                      err_sat_c = err_c[ErrW-1:0];

    priority if (angle_r < Angle20)  ac_c = Angle20;
    else if (angle_r > Angle160)     ac_c = Angle160;
    else                             ac_c = angle_r;
    if (ac_c >= Angle90) d_c = 13'(ac_c - Angle90);
    else                 d_c = 13'(Angle90 - ac_c);
    span_c = 16'd44800 - {3'd0, d_c};
    x_c    = {span_c, 6'd0} + 22'd437;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      corr_r <= below_c || above_c;
      err_r  <= err_sat_c;
      x_r    <= x_c;
    end
  end

  // correction product and reciprocal estimate
  logic [44:0] qprod_c;
  assign qprod_c = {23'd0, x_r} * {22'd0, Recip875};

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      p_r  <= $signed({1'b0, gain_r}) * err_r;
      q0_r <= qprod_c[44:32];
    end
  end

  // final: clamp correction, fix quotient, apply minima
  logic signed [CorrW-1:0] pt_c, t_c;
  logic signed [41:0]      c_c, cc_c;
  logic [22:0]             q875_c, rem_c;
  logic [12:0]             mn_c;
  logic signed [CmdW:0]    mn_s_c, tcmd_x_c, lcmd_x_c;
  logic signed [CmdW-1:0]  tout_c, lout_c;

  always_comb begin
    pt_c = p_r[CorrW-1] ? p_r + 41'sd127 : p_r;
    t_c  = pt_c >>> 7;
    c_c  = -{t_c[CorrW-1], t_c};
    priority if (c_c > CorrLimit)  cc_c = CorrLimit;
    else if (c_c < -CorrLimit)     cc_c = -CorrLimit;
    else                           cc_c = c_c;

    q875_c = {10'd0, q0_r} * Div875;
    rem_c  = {1'b0, x_r} - q875_c;
    mn_c   = q0_r + {12'd0, (rem_c >= Div875)};
    mn_s_c = {4'd0, mn_c};

    tcmd_x_c = {tcmd_r[CmdW-1], tcmd_r};
    tout_c   = tcmd_r;
    if (tzero_r) begin
      tout_c = '0;
    end else if (tpid_r) begin
      if (tcmd_x_c > 0 && tcmd_x_c < mn_s_c)       tout_c = mn_s_c[CmdW-1:0];
      else if (tcmd_x_c < 0 && tcmd_x_c > -mn_s_c) tout_c = CmdW'(-mn_s_c);
    end

    lcmd_x_c = {lcmd_r[CmdW-1], lcmd_r};
    lout_c   = lcmd_r;
    if (corr_r) begin
      lout_c = cc_c[CmdW-1:0];
    end else if (lpid_r) begin
      if (lcmd_x_c > 0 && lcmd_x_c < LiftMinCmd)       lout_c = LiftMinCmd[CmdW-1:0];
      else if (lcmd_x_c < 0 && lcmd_x_c > -LiftMinCmd) lout_c = CmdW'(-LiftMinCmd);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      bypass_out_r <= byp_r;
      if (byp_r) begin
        lift_out_r      <= lcmd_r;
        turret_out_r    <= tcmd_r;
        corrected_out_r <= 1'b0;
      end else begin
        lift_out_r      <= lout_c;
        turret_out_r    <= tout_c;
        corrected_out_r <= corr_r;
      end
    end
  end

  assign out_lift_out       = lift_out_r;
  assign out_turret_out     = turret_out_r;
  assign out_bypass_active  = bypass_out_r;
  assign out_lift_corrected = corrected_out_r;

endmodule

/* design/arm_motor_command_envelope_limiter_top.sv */
// Top level of the arm motor command envelope limiter.
`timescale 1ns / 1ps
// Usage
//  - Input channel (in_valid/in_ready): one transaction carries both motor
//    commands, both encoder counts, the two closed-loop flags and the level
//    of the bypass button. A rising button level between successive
//    transactions toggles bypass.
//  - Output channel (out_valid/out_ready): one transaction per input, giving
//    the validated commands, the bypass flag after this input's button edge,
//    and whether lift_out is an envelope correction.
//  - Config port: cfg_we writes cfg_wdata into register cfg_index at once.
//    Write only while no transaction is in flight.
//  - Sequence: the result is registered after the single-issue steps of the
//    controller (encoder multiply, angle and envelope, error and quotient
//    prep, correction and reciprocal multiply, final clamp); a new input is
//    taken only once the previous one has left its final step.
//  - Output is held in a register; a new input is taken while it waits.
//    If the receiver stalls, the following transaction parks in its final
//    step until the output register frees.
//  - Reset (rst_n low, synchronous) clears bypass, the button history, the
//    handshake state and restores the config defaults.

module arm_motor_command_envelope_limiter_top import amcel_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgW-1:0]          cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CmdW-1:0]   in_lift_cmd,
  input  logic signed [CmdW-1:0]   in_turret_cmd,
  input  logic signed [CountW-1:0] in_lift_count,
  input  logic signed [CountW-1:0] in_turret_count,
  input  logic                     in_lift_is_pid,
  input  logic                     in_turret_is_pid,
  input  logic                     in_bypass_button,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CmdW-1:0]   out_lift_out,
  output logic signed [CmdW-1:0]   out_turret_out,
  output logic                     out_bypass_active,
  output logic                     out_lift_corrected
);

  dp_cmd_t cmd;

  // sequencer: one transaction at a time, output register decoupled
  amcel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and config storage
  amcel_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_lift_cmd        (in_lift_cmd),
    .in_turret_cmd      (in_turret_cmd),
    .in_lift_count      (in_lift_count),
    .in_turret_count    (in_turret_count),
    .in_lift_is_pid     (in_lift_is_pid),
    .in_turret_is_pid   (in_turret_is_pid),
    .in_bypass_button   (in_bypass_button),
    .cmd                (cmd),
    .out_lift_out       (out_lift_out),
    .out_turret_out     (out_turret_out),
    .out_bypass_active  (out_bypass_active),
    .out_lift_corrected (out_lift_corrected)
  );

endmodule

/* design/amcel_checker.sv */
// Port-level checker for the envelope limiter, bound to the top level.
`timescale 1ns / 1ps

module amcel_checker import amcel_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [CmdW-1:0]   out_lift_out,
  input logic signed [CmdW-1:0]   out_turret_out,
  input logic                     out_bypass_active,
  input logic                     out_lift_corrected
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lift_out) &&
      $stable(out_turret_out) && $stable(out_bypass_active) &&
      $stable(out_lift_corrected))
    else $error("stalled result changed");

  // one transaction in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_bypass_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bypass_active |-> !out_lift_corrected)
    else $error("correction flagged under bypass");

  a_corr_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lift_corrected |->
      (out_lift_out <= 16'sd9830) && (out_lift_out >= -16'sd9830))
    else $error("correction outside clamp");

endmodule

bind arm_motor_command_envelope_limiter_top amcel_checker u_amcel_checker (.*);
